>>> rtl/swc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package swc_pkg;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LOAD,
        ST_SUMS,
        ST_MUL_START,
        ST_MUL,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } state_t;

    localparam int SUM_W     = 64;
    localparam int SAMPLE_W  = 24;
    localparam int WIN_W     = 14;
    localparam int CORR_W    = 16;
    localparam int QUO_W     = 31;
    localparam int ROOT_W    = 16;
    localparam int CNT_W     = 5;

    localparam logic [WIN_W-1:0]  WINDOW_RESET = 14'd4096;
    localparam logic [CORR_W-1:0] CORR_MAX     = 16'h7FFF;
    localparam logic [QUO_W-1:0]  QUO_LIMIT    = 31'h4000_0000;

    // Order in which the six products of one pair are formed and accumulated.
    localparam logic [2:0] STEP_NEW_CROSS = 3'd0;
    localparam logic [2:0] STEP_NEW_LEFT  = 3'd1;
    localparam logic [2:0] STEP_NEW_RIGHT = 3'd2;
    localparam logic [2:0] STEP_OLD_CROSS = 3'd3;
    localparam logic [2:0] STEP_OLD_LEFT  = 3'd4;
    localparam logic [2:0] STEP_OLD_RIGHT = 3'd5;
    localparam logic [2:0] STEP_LAST      = 3'd6;

endpackage
`default_nettype wire

>>> rtl/stereo_window_correlation.sv
// Stereo phase-correlation meter over a sliding window of sample pairs.
// Input stream: s_axis_tdata carries the left sample in bits 23:0 and the
// right sample in bits 47:24, both signed Q1.23. Each input transaction
// produces exactly one output transaction on m_axis_tdata, the correlation
// coefficient as signed Q1.15, saturated to +32767 and zero when either
// channel has no energy in the window.
// The window length is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while the block is idle; the block itself has no check for it.
// A write clears the history and the running sums. An input pair goes
// through these steps in order: reading the leaving pair and updating the
// three sums with one shared sample multiplier, the two bit-serial 64 by 64
// multipliers, 31 restoring division steps, 16 square root steps and
// loading the output register. One pair is worked on at a time, so a new
// pair is accepted only after the last one has finished. When either power
// sum is zero the division and square root are skipped.
// The history is a single-port-write RAM; entries not yet written since the
// last clear are masked by a wrap flag, so no clearing pass is needed.
// Reset sets the window to 4096 pairs and clears the sums.
// A finished result waits in the output register while the next pair is
// accepted; if the receiver stalls, the block holds the following result
// until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module stereo_window_correlation #(
    parameter int MAX_WINDOW  = 8192,
    parameter int SAMPLE_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [13:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // left_sample [23:0], right_sample [47:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // correlation [15:0]
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WB = $clog2(MAX_WINDOW + 1);
    localparam int PW = 2 * SAMPLE_BITS;
    localparam int SW = swc_pkg::SUM_W;
    localparam int MW = 2 * SW;

    swc_pkg::state_t state_reg;
    swc_pkg::state_t state_next;

    logic [swc_pkg::WIN_W-1:0]  window_reg;
    logic [WB-1:0]              n_eff;
    logic [AW-1:0]              pos_reg;
    logic [WB-1:0]              pos_inc;
    logic                       wrapped_reg;

    logic signed [SAMPLE_BITS-1:0] new_l_reg;
    logic signed [SAMPLE_BITS-1:0] new_r_reg;
    logic signed [SAMPLE_BITS-1:0] old_l_reg;
    logic signed [SAMPLE_BITS-1:0] old_r_reg;
    logic signed [SAMPLE_BITS-1:0] op_a;
    logic signed [SAMPLE_BITS-1:0] op_b;
    logic signed [PW-1:0]          mult;
    logic signed [PW-1:0]          prod_reg;
    logic [SW-1:0]                 addend;
    logic [2:0]                    acc_idx;

    logic [SW-1:0] sum_cross_reg;
    logic [SW-1:0] sum_left_reg;
    logic [SW-1:0] sum_right_reg;
    logic [SW-1:0] mag;

    logic [swc_pkg::CNT_W-1:0] cnt_reg;
    logic                      neg_reg;
    logic                      zero_reg;

    logic [PW-1:0] rd_data;
    logic          in_accept;
    logic          ram_wr_en;
    logic          mul_start;
    logic          out_load;

    logic          sq_done;
    logic          den_done;
    logic [MW-1:0] sq_prod;
    logic [MW-1:0] den_prod;

    logic [MW:0]   rem_reg;
    logic [MW:0]   rem_sub;
    logic          rem_ge;
    logic [swc_pkg::QUO_W-1:0]  quo_reg;
    logic [swc_pkg::ROOT_W-1:0] root_reg;
    logic [swc_pkg::ROOT_W-1:0] root_trial;
    logic [2*swc_pkg::ROOT_W-1:0] root_sq;
    logic [swc_pkg::CORR_W-1:0] result;

    logic                       out_valid_reg;
    logic [swc_pkg::CORR_W-1:0] out_data_reg;

    // Effective window: zero acts as one, large values are clamped.
    always_comb
    begin
        if (window_reg == '0)
        begin
            n_eff = WB'(1);
        end
        else if (32'(window_reg) > 32'(MAX_WINDOW))
        begin
            n_eff = WB'(MAX_WINDOW);
        end
        else
        begin
            n_eff = WB'(window_reg);
        end
        pos_inc = WB'(pos_reg) + WB'(1);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swc_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = swc_pkg::ST_LOAD;
                end
            end
            swc_pkg::ST_LOAD:
            begin
                state_next = swc_pkg::ST_SUMS;
            end
            swc_pkg::ST_SUMS:
            begin
                if (cnt_reg[2:0] == swc_pkg::STEP_LAST)
                begin
                    state_next = swc_pkg::ST_MUL_START;
                end
            end
            swc_pkg::ST_MUL_START:
            begin
                state_next = swc_pkg::ST_MUL;
            end
            swc_pkg::ST_MUL:
            begin
                if (den_done)
                begin
                    state_next = zero_reg ? swc_pkg::ST_DONE : swc_pkg::ST_DIV;
                end
            end
            swc_pkg::ST_DIV:
            begin
                if (cnt_reg == swc_pkg::CNT_W'(swc_pkg::QUO_W - 1))
                begin
                    state_next = swc_pkg::ST_SQRT;
                end
            end
            swc_pkg::ST_SQRT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = swc_pkg::ST_DONE;
                end
            end
            swc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = swc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        s_axis_tready = (state_reg == swc_pkg::ST_IDLE);
        ram_wr_en     = (state_reg == swc_pkg::ST_LOAD);
        mul_start     = (state_reg == swc_pkg::ST_MUL_START);
        out_load      = (state_reg == swc_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready);
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Shared sample multiplier and sum update selection.
    always_comb
    begin
        case (cnt_reg[2:0])
            swc_pkg::STEP_NEW_CROSS:
            begin
                op_a = new_l_reg;
                op_b = new_r_reg;
            end
            swc_pkg::STEP_NEW_LEFT:
            begin
                op_a = new_l_reg;
                op_b = new_l_reg;
            end
            swc_pkg::STEP_NEW_RIGHT:
            begin
                op_a = new_r_reg;
                op_b = new_r_reg;
            end
            swc_pkg::STEP_OLD_CROSS:
            begin
                op_a = old_l_reg;
                op_b = old_r_reg;
            end
            swc_pkg::STEP_OLD_LEFT:
            begin
                op_a = old_l_reg;
                op_b = old_l_reg;
            end
            default:
            begin
                op_a = old_r_reg;
                op_b = old_r_reg;
            end
        endcase
        mult    = op_a * op_b;
        addend  = {{(SW - PW){prod_reg[PW-1]}}, prod_reg};
        acc_idx = cnt_reg[2:0] - 3'd1;
        mag     = sum_cross_reg[SW-1] ? (SW'(0) - sum_cross_reg) : sum_cross_reg;
    end

    // Division and square root steps.
    always_comb
    begin
        rem_ge     = rem_reg >= {1'b0, den_prod};
        rem_sub    = rem_ge ? (rem_reg - {1'b0, den_prod}) : rem_reg;
        root_trial = root_reg | (swc_pkg::ROOT_W'(1) << cnt_reg[3:0]);
        root_sq    = root_trial * root_trial;
        if (zero_reg)
        begin
            result = '0;
        end
        else if (neg_reg)
        begin
            result = swc_pkg::CORR_W'(0) - root_reg;
        end
        else if (root_reg > swc_pkg::CORR_MAX)
        begin
            result = swc_pkg::CORR_MAX;
        end
        else
        begin
            result = root_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swc_pkg::ST_IDLE;
            window_reg    <= swc_pkg::WINDOW_RESET;
            pos_reg       <= '0;
            wrapped_reg   <= 1'b0;
            sum_cross_reg <= '0;
            sum_left_reg  <= '0;
            sum_right_reg <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                window_reg    <= cfg_wr_data;
                pos_reg       <= '0;
                wrapped_reg   <= 1'b0;
                sum_cross_reg <= '0;
                sum_left_reg  <= '0;
                sum_right_reg <= '0;
            end
            else if (state_reg == swc_pkg::ST_LOAD)
            begin
                if (pos_inc == n_eff)
                begin
                    pos_reg     <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    pos_reg <= AW'(pos_inc);
                end
            end
            else if (state_reg == swc_pkg::ST_SUMS && cnt_reg[2:0] != swc_pkg::STEP_NEW_CROSS)
            begin
                case (acc_idx)
                    swc_pkg::STEP_NEW_CROSS: sum_cross_reg <= sum_cross_reg + addend;
                    swc_pkg::STEP_NEW_LEFT:  sum_left_reg  <= sum_left_reg + addend;
                    swc_pkg::STEP_NEW_RIGHT: sum_right_reg <= sum_right_reg + addend;
                    swc_pkg::STEP_OLD_CROSS: sum_cross_reg <= sum_cross_reg - addend;
                    swc_pkg::STEP_OLD_LEFT:  sum_left_reg  <= sum_left_reg - addend;
                    default:                 sum_right_reg <= sum_right_reg - addend;
                endcase
            end

            case (state_reg)
                swc_pkg::ST_LOAD:  cnt_reg <= '0;
                swc_pkg::ST_SUMS:  cnt_reg <= cnt_reg + 1'b1;
                swc_pkg::ST_MUL:   cnt_reg <= '0;
                swc_pkg::ST_DIV:
                begin
                    if (cnt_reg == swc_pkg::CNT_W'(swc_pkg::QUO_W - 1))
                    begin
                        cnt_reg <= swc_pkg::CNT_W'(swc_pkg::ROOT_W - 1);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                swc_pkg::ST_SQRT:  cnt_reg <= cnt_reg - 1'b1;
                default:           cnt_reg <= cnt_reg;
            endcase

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            new_l_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            new_r_reg <= s_axis_tdata[swc_pkg::SAMPLE_W+SAMPLE_BITS-1:swc_pkg::SAMPLE_W];
        end
        if (state_reg == swc_pkg::ST_LOAD)
        begin
            old_l_reg <= wrapped_reg ? rd_data[SAMPLE_BITS-1:0] : '0;
            old_r_reg <= wrapped_reg ? rd_data[PW-1:SAMPLE_BITS] : '0;
        end
        prod_reg <= mult;
        if (state_reg == swc_pkg::ST_MUL_START)
        begin
            neg_reg  <= sum_cross_reg[SW-1];
            zero_reg <= (sum_left_reg == '0) || (sum_right_reg == '0);
        end
        if (state_reg == swc_pkg::ST_MUL)
        begin
            rem_reg  <= {1'b0, sq_prod};
            quo_reg  <= '0;
            root_reg <= '0;
        end
        if (state_reg == swc_pkg::ST_DIV)
        begin
            rem_reg <= {rem_sub[MW-1:0], 1'b0};
            quo_reg <= {quo_reg[swc_pkg::QUO_W-2:0], rem_ge};
        end
        if (state_reg == swc_pkg::ST_SQRT && root_sq <= {1'b0, quo_reg})
        begin
            root_reg <= root_trial;
        end
        if (out_load)
        begin
            out_data_reg <= result;
        end
    end

    swc_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WINDOW)
    ) u_history (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data ({new_r_reg, new_l_reg}),
        .rd_en   (in_accept),
        .rd_addr (pos_reg),
        .rd_data (rd_data)
    );

    swc_serial_mul #(
        .W (SW)
    ) u_mul_cross (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mag),
        .b       (mag),
        .done    (sq_done),
        .product (sq_prod)
    );

    swc_serial_mul #(
        .W (SW)
    ) u_mul_power (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (sum_left_reg),
        .b       (sum_right_reg),
        .done    (den_done),
        .product (den_prod)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // The write position always stays inside the effective window.
    assert property (@(posedge clk) disable iff (!rst_n) WB'(pos_reg) < n_eff)
        else $error("write position outside window");

    // Both serial multipliers are started together and must finish together.
    assert property (@(posedge clk) disable iff (!rst_n) sq_done == den_done)
        else $error("serial multipliers out of step");

    // By Cauchy-Schwarz the squared ratio never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swc_pkg::ST_SQRT) |-> (quo_reg <= swc_pkg::QUO_LIMIT))
        else $error("correlation ratio above one");

endmodule
`default_nettype wire

>>> rtl/swc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module swc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> rtl/swc_serial_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module swc_serial_mul #(
    parameter int W = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           done,
    output logic [2*W-1:0] product
);

    localparam int CW = $clog2(W);

    logic [2*W-1:0] p_reg;
    logic [2*W-1:0] p_next;
    logic [W-1:0]   a_reg;
    logic [W:0]     upper;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    // One multiplier bit is consumed per cycle, least significant first.
    always_comb
    begin
        upper  = {1'b0, p_reg[2*W-1:W]} + (p_reg[0] ? {1'b0, a_reg} : '0);
        p_next = {upper, p_reg[W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg <= {{W{1'b0}}, b};
            a_reg <= a;
        end
        else if (busy_reg)
        begin
            p_reg <= p_next;
        end
    end

    assign done    = done_reg;
    assign product = p_reg;

endmodule
`default_nettype wire

>>> bench/stereo_window_correlation_tb.sv
`timescale 1ns / 1ps
module stereo_window_correlation_tb;

    localparam int HIST_DEPTH = 8192;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 160;
    localparam int MODEL_DEPTH = 2048;

    typedef struct {
        bit          is_cfg;
        logic [23:0] left;
        logic [23:0] right;
        bit          fixed;
        logic [15:0] result;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [13:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;     // left_sample [23:0], right_sample [47:24]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // correlation [15:0]

    logic [15:0] corr_model[MODEL_DEPTH];
    int          model_wr = 0;
    int          model_rd = 0;
    int          errors = 0;
    int          idle_cycles = 0;
    bit          no_gaps;

    logic [13:0] win_reg;
    longint      hist_l[HIST_DEPTH];
    longint      hist_r[HIST_DEPTH];
    int          wr_pos;
    longint      acc_cross;
    longint      acc_left;
    longint      acc_right;

    stereo_window_correlation uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic clear_window_state(input logic [13:0] win);
        win_reg = win;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            hist_l[i] = 0;
            hist_r[i] = 0;
        end
        wr_pos = 0;
        acc_cross = 0;
        acc_left = 0;
        acc_right = 0;
    endtask

    function automatic logic [15:0] next_correlation(input logic [23:0] lraw,
                                                     input logic [23:0] rraw);
        longint       l;
        longint       r;
        int           n;
        int           pos;
        logic [63:0]  mag;
        logic [191:0] den;
        logic [191:0] num;
        logic [191:0] lhs;
        logic [31:0]  q;
        logic [31:0]  c;
        l = longint'($signed(lraw));
        r = longint'($signed(rraw));
        n = (win_reg == 0) ? 1 : ((win_reg > HIST_DEPTH) ? HIST_DEPTH : int'(win_reg));
        pos = (wr_pos >= n) ? 0 : wr_pos;
        acc_cross = acc_cross + l * r - hist_l[pos] * hist_r[pos];
        acc_left = acc_left + l * l - hist_l[pos] * hist_l[pos];
        acc_right = acc_right + r * r - hist_r[pos] * hist_r[pos];
        hist_l[pos] = l;
        hist_r[pos] = r;
        pos++;
        wr_pos = (pos >= n) ? 0 : pos;
        if (acc_left == 0 || acc_right == 0)
            return 16'd0;
        mag = (acc_cross < 0) ? 64'(-acc_cross) : 64'(acc_cross);
        den = {128'd0, 64'(acc_left)} * {128'd0, 64'(acc_right)};
        num = ({128'd0, mag} * {128'd0, mag}) << 30;
        q = 0;
        for (int b = 15; b >= 0; b--)
        begin
            c = q | (32'd1 << b);
            lhs = ({160'd0, c} * {160'd0, c}) * den;
            if (lhs <= num)
                q = c;
        end
        if (acc_cross < 0)
            return 16'(-q);
        return (q > 32767) ? swc_pkg::CORR_MAX : q[15:0];
    endfunction

    task automatic send_pair(input logic [23:0] l, input logic [23:0] r,
                             input bit fixed, input logic [15:0] result);
        int          gap;
        logic [15:0] predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {r, l};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = next_correlation(l, r);
        corr_model[model_wr % MODEL_DEPTH] = fixed ? result : predicted;
        model_wr++;
    endtask

    task automatic write_window(input logic [13:0] win);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (model_rd != model_wr)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= win;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        clear_window_state(win);
    endtask

    function automatic logic [23:0] pick_sample(input int mode, input logic [23:0] other);
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 15)) - 8);
            3: return (mode == 1) ? other : 24'(-$signed(other));
            default: return 24'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int          gap;
        logic [15:0] want;
        m_axis_tready = 1'b0;
        forever
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            if (model_rd == model_wr)
            begin
                $error("correlation: unexpected transaction, actual %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = corr_model[model_rd % MODEL_DEPTH];
                model_rd++;
                if (m_axis_tdata !== want)
                begin
                    $error("correlation: expected %h, actual %h", want, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t   rows[$];
        logic [13:0] win;
        logic [23:0] l;
        int          count;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        clear_window_state(swc_pkg::WINDOW_RESET);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{0, 24'h000000, 24'h000000, 1, 16'h0000},
            '{0, 24'h7FFFFF, 24'h7FFFFF, 1, 16'h7FFF},
            '{0, 24'h800000, 24'h800000, 0, 16'h0000},
            '{0, 24'h800000, 24'h7FFFFF, 0, 16'h0000},
            '{0, 24'h000001, 24'hFFFFFF, 0, 16'h0000},
            '{1, 24'h000001, 24'h000000, 0, 16'h0000},
            '{0, 24'h800000, 24'h7FFFFF, 1, 16'h8000},
            '{0, 24'h800000, 24'h800000, 1, 16'h7FFF},
            '{0, 24'h000000, 24'h000005, 1, 16'h0000},
            '{0, 24'h7FFFFF, 24'h000000, 1, 16'h0000},
            '{0, 24'h000001, 24'h000001, 1, 16'h7FFF},
            '{0, 24'hAAAAAA, 24'h555555, 0, 16'h0000},
            '{1, 24'h000000, 24'h000000, 0, 16'h0000},
            '{0, 24'h123456, 24'hFEDCBA, 0, 16'h0000},
            '{0, 24'h000000, 24'h000000, 0, 16'h0000},
            '{1, 24'h000003, 24'h000000, 0, 16'h0000},
            '{0, 24'h400000, 24'h400001, 0, 16'h0000},
            '{0, 24'hC00000, 24'h3FFFFF, 0, 16'h0000},
            '{0, 24'h7FFFFF, 24'h800000, 0, 16'h0000},
            '{0, 24'h000000, 24'h000000, 0, 16'h0000},
            '{0, 24'h000000, 24'h000000, 0, 16'h0000},
            '{0, 24'h000000, 24'h000000, 0, 16'h0000}
        };
        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
                write_window(rows[i].left[13:0]);
            else
                send_pair(rows[i].left, rows[i].right, rows[i].fixed, rows[i].result);
        end

        for (int phase = 0; phase < 14; phase++)
        begin
            case (phase)
                0: win = 14'd8192;
                1: win = 14'd16383;
                2: win = 14'd1;
                3: win = 14'd0;
                default: win = 14'($urandom_range(2, 40));
            endcase
            write_window(win);
            no_gaps = (phase % 4 == 3);
            count = (phase < 2) ? 40 : 60;
            for (int k = 0; k < count; k++)
            begin
                l = pick_sample(0, 24'h0);
                send_pair(l, pick_sample($urandom_range(0, 1), l), 0, 16'h0000);
            end
        end
        no_gaps = 1'b0;
        write_window(14'd4096);
        for (int k = 0; k < 20; k++)
        begin
            l = pick_sample(0, 24'h0);
            send_pair(l, pick_sample(1, l), 0, 16'h0000);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (model_rd != model_wr)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
